>>> rtl/psd_pkg.sv
package psd_pkg;

  // field and datapath widths
  localparam int CW     = 24;          // external fields
  localparam int DW     = CW + 1;      // coordinate differences
  localparam int PW     = 2 * DW;      // products of differences
  localparam int NUMW   = PW + 1;      // r and s numerators
  localparam int SQW    = PW;          // sums of squares
  localparam int FRAC   = 16;          // fraction bits of r and s
  localparam int QW     = CW - 1;      // quotient magnitude bits
  localparam int LOWW   = QW - FRAC;   // dividend bits shifted in by the divider
  localparam int ROOTW  = SQW / 2;     // square root bits
  localparam int RREMW  = ROOTW + 3;   // square root partial remainder
  localparam int FPW    = CW + DW;     // foot offset product
  localparam int OFFW   = FPW - FRAC;  // foot offset after scaling
  localparam int CFG_IW = 3;

  localparam int DIV_LAT  = QW + 3;
  localparam int SQRT_LAT = ROOTW + 1;
  localparam int PIPE_LAT = 11 + DIV_LAT + SQRT_LAT;

  localparam logic signed [CW-1:0] SMAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] SMIN = {1'b1, {(CW-1){1'b0}}};
  localparam logic        [CW-1:0] UMAX = {CW{1'b1}};
  localparam logic signed [CW-1:0] R_OUT_OF_WAY = CW'(6553600);

  typedef enum logic [CFG_IW-1:0] {
    REG_AX = 3'd0,
    REG_AY = 3'd1,
    REG_BX = 3'd2,
    REG_BY = 3'd3
  } psd_reg_t;

  typedef struct packed {
    logic signed [CW-1:0] point_x;
    logic signed [CW-1:0] point_y;
  } psd_point_t;

  typedef struct packed {
    logic signed [CW-1:0] param_r;
    logic signed [CW-1:0] param_s;
    logic signed [CW-1:0] proj_x;
    logic signed [CW-1:0] proj_y;
    logic        [CW-1:0] seg_distance;
    logic signed [CW-1:0] near_x;
    logic signed [CW-1:0] near_y;
    logic                 zero_length;
  } psd_result_t;

endpackage

>>> rtl/point_segment_distance.sv
// Point to segment distance, one query point per beat.
// Configuration: write seg_ax, seg_ay, seg_bx, seg_by (indexes 0..3) over the
// cfg_valid/cfg_ready channel; cfg_ready is always high and other indexes are
// ignored. Write only while no query is in flight.
// Input: a point beat is taken at each rising edge with start high and busy
// low. busy stays low, so a new point may enter every cycle.
// Output: done is high for one cycle with the result of each point, in input
// order. Throughput is one point per cycle. Each point passes through the
// divider for r and s (one quotient bit in each of its 23 step stages), then
// the foot point datapath and the square root (one root bit in each of its
// 25 step stages).
// The receiver cannot stall; results are simply presented for one cycle.
// Reset clears the segment registers to zero and drops every point in flight.
module point_segment_distance
  import psd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  psd_point_t        point,
  output logic              done,
  output psd_result_t       result,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [CW-1:0]     cfg_data
);

  typedef struct packed {
    logic                 zl;
    logic                 outside;
    logic                 near_b;
    logic                 a_gt;
    logic                 force100;
    logic signed [CW-1:0] px;
    logic signed [CW-1:0] py;
    logic [SQW-1:0]       da2;
    logic [SQW-1:0]       db2;
  } psd_side_t;

  typedef struct packed {
    psd_side_t            sd;
    logic signed [CW-1:0] r_q;
    logic signed [CW-1:0] s_q;
    logic signed [CW-1:0] foot_x;
    logic signed [CW-1:0] foot_y;
  } psd_tail_t;

  function automatic logic signed [DW-1:0] sx(input logic signed [CW-1:0] v);
    return {v[CW-1], v};
  endfunction

  function automatic logic signed [CW-1:0] sat24(input logic signed [OFFW:0] v);
    if (v[OFFW:CW-1] == '0 || v[OFFW:CW-1] == '1) begin
      return v[CW-1:0];
    end
    return v[OFFW] ? SMIN : SMAX;
  endfunction

  logic signed [CW-1:0] seg_ax, seg_ay, seg_bx, seg_by;
  logic signed [DW-1:0] cfg_dx, cfg_dy;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign cfg_dx    = sx(seg_bx) - sx(seg_ax);
  assign cfg_dy    = sx(seg_by) - sx(seg_ay);

  always_ff @(posedge clk) begin
    if (rst) begin
      seg_ax <= '0;
      seg_ay <= '0;
      seg_bx <= '0;
      seg_by <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_AX:  seg_ax <= cfg_data;
        REG_AY:  seg_ay <= cfg_data;
        REG_BX:  seg_bx <= cfg_data;
        REG_BY:  seg_by <= cfg_data;
        default: ;
      endcase
    end
  end

  // front: differences, products, sums
  logic                 v1, v2, v3, v4;
  logic signed [CW-1:0] px1, py1, px2, py2, px3, py3, px4, py4;
  logic signed [DW-1:0] ex2, ey2, gx2, gy2, dx2, dy2;
  logic signed [PW-1:0] rx3, ry3, sa3, sb3, ea3, eb3, ga3, gb3, la3, lb3;
  logic signed [NUMW-1:0] numr4, nums4;
  logic [SQW-1:0]       len4, da4, db4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      v1 <= start && !busy;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    px1 <= point.point_x;
    py1 <= point.point_y;

    px2 <= px1;
    py2 <= py1;
    ex2 <= sx(px1) - sx(seg_ax);
    ey2 <= sx(py1) - sx(seg_ay);
    gx2 <= sx(px1) - sx(seg_bx);
    gy2 <= sx(py1) - sx(seg_by);
    dx2 <= cfg_dx;
    dy2 <= cfg_dy;

    px3 <= px2;
    py3 <= py2;
    rx3 <= ex2 * dx2;
    ry3 <= ey2 * dy2;
    sa3 <= ex2 * dy2;
    sb3 <= ey2 * dx2;
    ea3 <= ex2 * ex2;
    eb3 <= ey2 * ey2;
    ga3 <= gx2 * gx2;
    gb3 <= gy2 * gy2;
    la3 <= dx2 * dx2;
    lb3 <= dy2 * dy2;

    px4   <= px3;
    py4   <= py3;
    numr4 <= {rx3[PW-1], rx3} + {ry3[PW-1], ry3};
    nums4 <= {sa3[PW-1], sa3} - {sb3[PW-1], sb3};
    len4  <= $unsigned(la3) + $unsigned(lb3);
    da4   <= $unsigned(ea3) + $unsigned(eb3);
    db4   <= $unsigned(ga3) + $unsigned(gb3);
  end

  logic signed [CW-1:0] rq30, sq30;

  psd_div u_div_r (
    .clk  (clk),
    .num  (numr4),
    .den  (len4),
    .quot (rq30)
  );

  psd_div u_div_s (
    .clk  (clk),
    .num  (nums4),
    .den  (len4),
    .quot (sq30)
  );

  // side data waits alongside the dividers
  logic [DIV_LAT-1:0] vline;
  psd_side_t          side [0:DIV_LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vline <= '0;
    end else begin
      vline <= {vline[DIV_LAT-2:0], v4};
    end
  end

  always_ff @(posedge clk) begin
    side[0].zl       <= len4 == '0;
    side[0].outside  <= numr4[NUMW-1] || numr4 == '0 || numr4 > $signed({1'b0, len4});
    side[0].near_b   <= db4 < da4;
    side[0].a_gt     <= db4 > da4;
    side[0].force100 <= (py4 > seg_ay && py4 > seg_by) ||
                        (px4 > seg_ax && px4 > seg_bx) ||
                        (px4 < seg_ax && px4 < seg_bx);
    side[0].px       <= px4;
    side[0].py       <= py4;
    side[0].da2      <= da4;
    side[0].db2      <= db4;
    for (int i = 1; i < DIV_LAT; i++) begin
      side[i] <= side[i-1];
    end
  end

  // foot point: A + r*(B-A), scaled with truncation toward zero
  logic                  v31, v32, v33, v34, v35, v36;
  psd_tail_t             t31, t32, t33, t34, t35, t36;
  logic signed [FPW-1:0] prx31, pry31, biasx, biasy;
  logic signed [OFFW-1:0] offx32, offy32;
  logic signed [OFFW:0]  sumx, sumy;
  logic signed [DW-1:0]  fdx34, fdy34;
  logic signed [PW-1:0]  fsx35, fsy35;
  logic [SQW-1:0]        foot2_36;

  assign biasx = prx31 + (prx31[FPW-1] ? {{(FPW-FRAC){1'b0}}, {FRAC{1'b1}}} : '0);
  assign biasy = pry31 + (pry31[FPW-1] ? {{(FPW-FRAC){1'b0}}, {FRAC{1'b1}}} : '0);
  assign sumx  = {{(OFFW+1-CW){seg_ax[CW-1]}}, seg_ax} + {offx32[OFFW-1], offx32};
  assign sumy  = {{(OFFW+1-CW){seg_ay[CW-1]}}, seg_ay} + {offy32[OFFW-1], offy32};

  always_ff @(posedge clk) begin
    if (rst) begin
      v31 <= 1'b0;
      v32 <= 1'b0;
      v33 <= 1'b0;
      v34 <= 1'b0;
      v35 <= 1'b0;
      v36 <= 1'b0;
    end else begin
      v31 <= vline[DIV_LAT-1];
      v32 <= v31;
      v33 <= v32;
      v34 <= v33;
      v35 <= v34;
      v36 <= v35;
    end
  end

  always_ff @(posedge clk) begin
    t31.sd     <= side[DIV_LAT-1];
    t31.r_q    <= rq30;
    t31.s_q    <= sq30;
    t31.foot_x <= '0;
    t31.foot_y <= '0;
    prx31      <= rq30 * cfg_dx;
    pry31      <= rq30 * cfg_dy;

    t32    <= t31;
    offx32 <= biasx[FPW-1:FRAC];
    offy32 <= biasy[FPW-1:FRAC];

    t33.sd     <= t32.sd;
    t33.r_q    <= t32.r_q;
    t33.s_q    <= t32.s_q;
    t33.foot_x <= sat24(sumx);
    t33.foot_y <= sat24(sumy);

    t34   <= t33;
    fdx34 <= sx(t33.foot_x) - sx(t33.sd.px);
    fdy34 <= sx(t33.foot_y) - sx(t33.sd.py);

    t35   <= t34;
    fsx35 <= fdx34 * fdx34;
    fsy35 <= fdy34 * fdy34;

    t36      <= t35;
    foot2_36 <= $unsigned(fsx35) + $unsigned(fsy35);
  end

  // root 1 takes |PB| when r is outside, else |P-foot|; root 2 takes |PA|
  logic [ROOTW-1:0] root1, root2;

  psd_sqrt u_sqrt_1 (
    .clk  (clk),
    .n    (t36.sd.outside ? t36.sd.db2 : foot2_36),
    .root (root1)
  );

  psd_sqrt u_sqrt_2 (
    .clk  (clk),
    .n    (t36.sd.da2),
    .root (root2)
  );

  logic [SQRT_LAT-1:0] vl2;
  psd_tail_t           tl [0:SQRT_LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vl2 <= '0;
    end else begin
      vl2 <= {vl2[SQRT_LAT-2:0], v36};
    end
  end

  always_ff @(posedge clk) begin
    tl[0] <= t36;
    for (int i = 1; i < SQRT_LAT; i++) begin
      tl[i] <= tl[i-1];
    end
  end

  // result assembly
  psd_tail_t        tf;
  psd_result_t      res_next;
  logic [ROOTW-1:0] dist_raw;

  assign tf = tl[SQRT_LAT-1];

  always_comb begin
    res_next = '0;
    dist_raw = root1;
    if (tf.sd.zl) begin
      res_next.zero_length = 1'b1;
    end else begin
      res_next.near_x  = tf.sd.near_b ? seg_bx : seg_ax;
      res_next.near_y  = tf.sd.near_b ? seg_by : seg_ay;
      res_next.param_s = tf.s_q;
      if (tf.sd.outside) begin
        dist_raw         = tf.sd.a_gt ? root2 : root1;
        res_next.param_r = tf.r_q;
        res_next.proj_x  = (root1[ROOTW-1:CW-1] != '0) ? SMAX : root1[CW-1:0];
        res_next.proj_y  = (root2[ROOTW-1:CW-1] != '0) ? SMAX : root2[CW-1:0];
      end else begin
        res_next.param_r = tf.sd.force100 ? R_OUT_OF_WAY : tf.r_q;
        res_next.proj_x  = tf.foot_x;
        res_next.proj_y  = tf.foot_y;
      end
      res_next.seg_distance = dist_raw[ROOTW-1] ? UMAX : dist_raw[CW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vl2[SQRT_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    result <= res_next;
  end

`ifndef ASSERT_OFF
  a_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, PIPE_LAT))
    else $error("result beat without matching point beat");

  a_zero_fields: assert property (@(posedge clk) disable iff (rst)
    done && result.zero_length |->
      result.seg_distance == '0 && result.param_r == '0 && result.near_x == '0)
    else $error("zero length result carries data");

  a_zero_cfg: assert property (@(posedge clk) disable iff (rst)
    done && result.zero_length |-> seg_ax == seg_bx && seg_ay == seg_by)
    else $error("zero length flagged on a real segment");

  a_near_end: assert property (@(posedge clk) disable iff (rst)
    done && !result.zero_length |->
      (result.near_x == seg_ax && result.near_y == seg_ay) ||
      (result.near_x == seg_bx && result.near_y == seg_by))
    else $error("nearer endpoint is neither endpoint");
`endif

endmodule

>>> rtl/psd_div.sv
module psd_div
  import psd_pkg::*;
(
  input  logic                   clk,
  input  logic signed [NUMW-1:0] num,
  input  logic        [SQW-1:0]  den,
  output logic signed [CW-1:0]   quot
);

  logic [NUMW-1:0] mag_a;
  logic            neg_a;
  logic [SQW-1:0]  den_a;

  logic [SQW-1:0]  rem_s [0:QW];
  logic [QW-1:0]   q_s   [0:QW];
  logic [LOWW-1:0] sh_s  [0:QW];
  logic [SQW-1:0]  den_s [0:QW];
  logic            neg_s [0:QW];
  logic            sat_s [0:QW];

  logic [CW-1:0]   qx;

  always_ff @(posedge clk) begin
    neg_a <= num[NUMW-1];
    mag_a <= num[NUMW-1] ? NUMW'(-num) : num;
    den_a <= den;
  end

  // quotient fits QW bits unless mag >= den * 2^LOWW
  always_ff @(posedge clk) begin
    sat_s[0] <= (mag_a >> LOWW) >= {1'b0, den_a};
    rem_s[0] <= SQW'(mag_a >> LOWW);
    sh_s[0]  <= mag_a[LOWW-1:0];
    q_s[0]   <= '0;
    den_s[0] <= den_a;
    neg_s[0] <= neg_a;
  end

  for (genvar k = 0; k < QW; k++) begin : g_step
    logic [SQW:0] t;
    logic         ge;
    assign t  = {rem_s[k], sh_s[k][LOWW-1]};
    assign ge = t >= {1'b0, den_s[k]};
    always_ff @(posedge clk) begin
      rem_s[k+1] <= ge ? SQW'(t - {1'b0, den_s[k]}) : t[SQW-1:0];
      q_s[k+1]   <= {q_s[k][QW-2:0], ge};
      sh_s[k+1]  <= {sh_s[k][LOWW-2:0], 1'b0};
      den_s[k+1] <= den_s[k];
      neg_s[k+1] <= neg_s[k];
      sat_s[k+1] <= sat_s[k];
    end
  end

  assign qx = {{(CW-QW){1'b0}}, q_s[QW]};

  always_ff @(posedge clk) begin
    if (sat_s[QW]) begin
      quot <= neg_s[QW] ? SMIN : SMAX;
    end else begin
      quot <= neg_s[QW] ? -qx : qx;
    end
  end

endmodule

>>> rtl/psd_sqrt.sv
module psd_sqrt
  import psd_pkg::*;
(
  input  logic             clk,
  input  logic [SQW-1:0]   n,
  output logic [ROOTW-1:0] root
);

  logic [SQW-1:0]   op_s   [0:ROOTW];
  logic [RREMW-1:0] rem_s  [0:ROOTW];
  logic [ROOTW-1:0] root_s [0:ROOTW];

  always_ff @(posedge clk) begin
    op_s[0]   <= n;
    rem_s[0]  <= '0;
    root_s[0] <= '0;
  end

  // one result bit per stage, two operand bits brought down each time
  for (genvar k = 0; k < ROOTW; k++) begin : g_step
    logic [RREMW-1:0] t;
    logic [RREMW-1:0] trial;
    logic             ge;
    assign t     = {rem_s[k][RREMW-3:0], op_s[k][SQW-1 -: 2]};
    assign trial = {1'b0, root_s[k], 2'b01};
    assign ge    = t >= trial;
    always_ff @(posedge clk) begin
      rem_s[k+1]  <= ge ? t - trial : t;
      root_s[k+1] <= {root_s[k][ROOTW-2:0], ge};
      op_s[k+1]   <= {op_s[k][SQW-3:0], 2'b00};
    end
  end

  assign root = root_s[ROOTW];

endmodule
